FILE: rtl/frp_pkg.sv
package frp_pkg;

    // Payload store depth, derived address width, and length and counter widths.
    localparam int MAX_PAYLOAD = 32;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W       = 6;
    localparam int CNT_W       = 6;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    // CRC-16/XMODEM polynomial.
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Fixed ping response.
    localparam int PING_LEN = 10;
    localparam logic [CNT_W-1:0] PING_LAST = CNT_W'(PING_LEN - 1);

    // Input operation codes.
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_ABORT   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    // Result kind codes.
    localparam logic [1:0] KIND_HDR     = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_TX      = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_START_CODE     = 3'd0;
    localparam logic [2:0] REG_ACK_CODE       = 3'd1;
    localparam logic [2:0] REG_NAK_CODE       = 3'd2;
    localparam logic [2:0] REG_ACK_ABORT_CODE = 3'd3;
    localparam logic [2:0] REG_COMMAND_CODE   = 3'd4;
    localparam logic [2:0] REG_DATA_CODE      = 3'd5;
    localparam logic [2:0] REG_PING_CODE      = 3'd6;
    localparam logic [2:0] REG_EXPECT_DATA    = 3'd7;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_TYPE,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_CRC_LO,
        PH_CRC_HI,
        PH_DATA
    } phase_t;

    // What an accepted request asks to be sent.
    typedef enum logic [2:0] {
        EV_NONE,
        EV_SYNC_ACK,
        EV_SYNC_ABORT,
        EV_NAK,
        EV_PING,
        EV_REJECT,
        EV_GOOD
    } event_t;

    // Which result the datapath forms for the output register.
    typedef enum logic [2:0] {
        EM_SYNC0,
        EM_SYNC1,
        EM_PING,
        EM_REJECT,
        EM_HDR,
        EM_PAY
    } emit_sel_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SYNC0,
        S_SYNC1,
        S_PING,
        S_REJECT,
        S_HDR,
        S_PAY
    } ctrl_state_t;

    typedef struct packed {
        logic      accept;
        logic      load;
        emit_sel_t sel;
    } ctrl_cmd_t;

    typedef struct packed {
        event_t ev;
        logic   out_free;
        logic   emit_last;
    } dp_status_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

    function automatic logic [7:0] ping_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h5A;
            4'd1:    b = 8'hA7;
            4'd4:    b = 8'h01;
            4'd5:    b = 8'h50;
            4'd8:    b = 8'h29;
            4'd9:    b = 8'hAE;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/frp_ram.sv
module frp_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/frp_ctrl.sv
module frp_ctrl
    import frp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (status.ev) inside
                        EV_SYNC_ACK, EV_SYNC_ABORT, EV_NAK: state_next = S_SYNC0;
                        EV_PING:   state_next = S_PING;
                        EV_REJECT: state_next = S_REJECT;
                        EV_GOOD:   state_next = S_HDR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SYNC0: if (status.out_free) state_next = S_SYNC1;
            S_HDR: begin
                if (status.out_free) begin
                    state_next = status.emit_last ? S_IDLE : S_PAY;
                end
            end
            S_SYNC1, S_PING, S_REJECT, S_PAY: begin
                if (status.out_free && status.emit_last) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready   = 1'b0;
        cmd.accept = 1'b0;
        cmd.load   = 1'b0;
        cmd.sel    = EM_SYNC0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            S_SYNC0: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_SYNC0;
            end
            S_SYNC1: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_SYNC1;
            end
            S_PING: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_PING;
            end
            S_REJECT: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_REJECT;
            end
            S_HDR: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_HDR;
            end
            S_PAY: begin
                cmd.load = status.out_free;
                cmd.sel  = EM_PAY;
            end
            default: begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/frp_dp.sv
module frp_dp
    import frp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       operation,
    input  logic [7:0]       rx_byte,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_addr,
    input  logic [7:0]       cfg_wdata,
    input  ctrl_cmd_t        cmd,
    output dp_status_t       status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [1:0]       m_kind,
    output logic [7:0]       m_data_byte,
    output logic [LEN_W-1:0] m_frame_length,
    output logic             m_last
);

    // Configuration registers.
    logic [7:0] start_code_reg, ack_code_reg, nak_code_reg, ack_abort_code_reg;
    logic [7:0] command_code_reg, data_code_reg, ping_code_reg;
    logic       expect_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg     <= 8'h5A;
            ack_code_reg       <= 8'hA1;
            nak_code_reg       <= 8'hA2;
            ack_abort_code_reg <= 8'hA3;
            command_code_reg   <= 8'hA4;
            data_code_reg      <= 8'hA5;
            ping_code_reg      <= 8'hA6;
            expect_data_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_START_CODE:     start_code_reg     <= cfg_wdata;
                REG_ACK_CODE:       ack_code_reg       <= cfg_wdata;
                REG_NAK_CODE:       nak_code_reg       <= cfg_wdata;
                REG_ACK_ABORT_CODE: ack_abort_code_reg <= cfg_wdata;
                REG_COMMAND_CODE:   command_code_reg   <= cfg_wdata;
                REG_DATA_CODE:      data_code_reg      <= cfg_wdata;
                REG_PING_CODE:      ping_code_reg      <= cfg_wdata;
                REG_EXPECT_DATA:    expect_data_reg    <= cfg_wdata[0];
                default:            expect_data_reg    <= expect_data_reg;
            endcase
        end
    end

    // Frame parser state.
    phase_t           phase_reg, phase_next;
    logic [7:0]       len_lo_reg, len_lo_next;
    logic [LEN_W-1:0] clamped_len_reg, clamped_len_next;
    logic [15:0]      rx_crc_reg, rx_crc_next;
    logic [15:0]      crc_reg, crc_next;
    logic [LEN_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             ack_pend_reg, ack_pend_next;
    logic             abort_pend_reg, abort_pend_next;
    logic [7:0]       sync_type_reg, sync_type_next;
    event_t           ev;

    logic [15:0]      crc_rx;
    logic [15:0]      len_full;
    logic [LEN_W-1:0] len_clamp;
    logic [LEN_W-1:0] byte_cnt_inc;
    logic [7:0]       expected_type;
    logic             ram_wr_en;

    assign crc_rx        = crc16_byte(crc_reg, rx_byte);
    assign len_full      = {rx_byte, len_lo_reg};
    assign len_clamp     = (len_full > 16'(MAX_PAYLOAD)) ? MAX_LEN : len_full[LEN_W-1:0];
    assign byte_cnt_inc  = byte_cnt_reg + LEN_W'(1);
    assign expected_type = expect_data_reg ? data_code_reg : command_code_reg;

    always_comb begin
        phase_next       = phase_reg;
        len_lo_next      = len_lo_reg;
        clamped_len_next = clamped_len_reg;
        rx_crc_next      = rx_crc_reg;
        crc_next         = crc_reg;
        byte_cnt_next    = byte_cnt_reg;
        ack_pend_next    = ack_pend_reg;
        abort_pend_next  = abort_pend_reg;
        ev               = EV_NONE;
        ram_wr_en        = 1'b0;

        case (operation)
            OP_ABORT: begin
                if (ack_pend_reg) begin
                    abort_pend_next = 1'b1;
                    ack_pend_next   = 1'b0;
                end
            end
            OP_RELEASE: begin
                if (ack_pend_reg) begin
                    ack_pend_next = 1'b0;
                    ev            = EV_SYNC_ACK;
                end else if (abort_pend_reg) begin
                    abort_pend_next = 1'b0;
                    ev              = EV_SYNC_ABORT;
                end
            end
            OP_BYTE: begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (rx_byte == start_code_reg) begin
                            crc_next   = crc16_byte(16'h0000, rx_byte);
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        if (rx_byte == ping_code_reg) begin
                            phase_next = PH_HUNT;
                            ev         = EV_PING;
                        end else if (rx_byte != expected_type) begin
                            phase_next = PH_HUNT;
                            ev         = EV_REJECT;
                        end else begin
                            crc_next   = crc_rx;
                            phase_next = PH_LEN_LO;
                        end
                    end
                    PH_LEN_LO: begin
                        len_lo_next = rx_byte;
                        phase_next  = PH_LEN_HI;
                    end
                    PH_LEN_HI: begin
                        clamped_len_next = len_clamp;
                        crc_next         = crc16_byte(crc_reg, 8'(len_clamp));
                        phase_next       = PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        // The high length byte is always zero after clamping; it
                        // is folded into the CRC here.
                        rx_crc_next = {8'h00, rx_byte};
                        crc_next    = crc16_byte(crc_reg, 8'h00);
                        phase_next  = PH_CRC_HI;
                    end
                    PH_CRC_HI: begin
                        rx_crc_next   = {rx_byte, rx_crc_reg[7:0]};
                        byte_cnt_next = '0;
                        if (clamped_len_reg == '0) begin
                            phase_next = PH_HUNT;
                            ev = (crc_reg == {rx_byte, rx_crc_reg[7:0]}) ? EV_GOOD : EV_NAK;
                        end else begin
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        ram_wr_en     = (byte_cnt_reg < MAX_LEN);
                        crc_next      = crc_rx;
                        byte_cnt_next = byte_cnt_inc;
                        if (byte_cnt_inc >= clamped_len_reg) begin
                            phase_next = PH_HUNT;
                            ev = (crc_rx == rx_crc_reg) ? EV_GOOD : EV_NAK;
                        end
                    end
                    default: phase_next = PH_HUNT;
                endcase
                if (ev == EV_GOOD) begin
                    ack_pend_next = 1'b1;
                end
            end
            default: ev = EV_NONE;
        endcase
    end

    always_comb begin
        case (ev)
            EV_SYNC_ACK:   sync_type_next = ack_code_reg;
            EV_SYNC_ABORT: sync_type_next = ack_abort_code_reg;
            EV_NAK:        sync_type_next = nak_code_reg;
            default:       sync_type_next = sync_type_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_HUNT;
            len_lo_reg      <= '0;
            clamped_len_reg <= '0;
            rx_crc_reg      <= '0;
            crc_reg         <= '0;
            byte_cnt_reg    <= '0;
            ack_pend_reg    <= 1'b0;
            abort_pend_reg  <= 1'b0;
        end else if (cmd.accept) begin
            phase_reg       <= phase_next;
            len_lo_reg      <= len_lo_next;
            clamped_len_reg <= clamped_len_next;
            rx_crc_reg      <= rx_crc_next;
            crc_reg         <= crc_next;
            byte_cnt_reg    <= byte_cnt_next;
            ack_pend_reg    <= ack_pend_next;
            abort_pend_reg  <= abort_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sync_type_reg <= sync_type_next;
        end
    end

    // Emission counter: ping byte index or payload index.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_inc;

    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.accept || (cmd.load && cmd.sel == EM_HDR)) begin
            cnt_next = '0;
        end else if (cmd.load) begin
            cnt_next = cnt_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Payload store; the read address runs one entry ahead when a payload
    // result is loaded so that the registered read keeps pace.
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    always_comb begin
        if (cmd.sel == EM_PAY) begin
            rd_addr = cmd.load ? cnt_inc[ADDR_W-1:0] : cnt_reg[ADDR_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    frp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.accept && ram_wr_en),
        .wr_addr (byte_cnt_reg[ADDR_W-1:0]),
        .wr_data (rx_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Result formation.
    logic [1:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;
    logic             emit_last;

    always_comb begin
        kind         = KIND_TX;
        data_byte    = 8'h00;
        frame_length = '0;
        emit_last    = 1'b0;
        unique case (cmd.sel)
            EM_SYNC0: data_byte = start_code_reg;
            EM_SYNC1: begin
                data_byte = sync_type_reg;
                emit_last = 1'b1;
            end
            EM_PING: begin
                data_byte = ping_byte(cnt_reg[3:0]);
                emit_last = (cnt_reg == PING_LAST);
            end
            EM_REJECT: begin
                kind      = KIND_REJECT;
                emit_last = 1'b1;
            end
            EM_HDR: begin
                kind         = KIND_HDR;
                frame_length = clamped_len_reg;
                emit_last    = (clamped_len_reg == '0);
            end
            EM_PAY: begin
                kind      = KIND_PAYLOAD;
                data_byte = rd_data;
                emit_last = (cnt_inc == clamped_len_reg);
            end
            default: kind = KIND_TX;
        endcase
    end

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       m_kind_reg;
    logic [7:0]       m_data_reg;
    logic [LEN_W-1:0] m_len_reg;
    logic             m_last_reg;

    assign m_valid_next = cmd.load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_kind_reg <= kind;
            m_data_reg <= data_byte;
            m_len_reg  <= frame_length;
            m_last_reg <= emit_last;
        end
    end

    assign status.ev        = ev;
    assign status.out_free  = !m_valid_reg || m_tready;
    assign status.emit_last = emit_last;

    assign m_tvalid       = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_data_byte    = m_data_reg;
    assign m_frame_length = m_len_reg;
    assign m_last         = m_last_reg;

endmodule

FILE: rtl/framed_packet_receiver.sv
// Framed packet receiver with CRC-16/XMODEM check and deferred acknowledge.
//
// Requests enter on the s_ stream: s_tuser carries the operation (received
// byte, abort pending ACK, release deferred sync) and s_tdata the byte.
// Results leave on the m_ stream: m_tuser is the result kind, m_tdata holds
// the data byte and the clamped frame length, m_tlast marks the final result
// caused by one request. Eight configuration registers are written through the cfg_
// port; the user must do so only while the block is idle, which the block does not enforce.
//
// Requests that produce no result leave the controller idle, so bytes can stream
// at one per cycle until a request produces results. Such a request occupies the
// block until all its results have been loaded, one at a time, into the single
// output register; a good frame emits its header and then its payload, read
// from the payload RAM. After a request is taken, the controller enters its
// emitting state, which loads the first result into the output register.
//
// Reset (synchronous, active low) restores the code registers, resumes the
// start byte hunt and clears the pending flags. When the downstream side
// holds m_tready low, the output register holds its result and s_tready
// stays low until every result of the current request has been loaded.
module framed_packet_receiver
    import frp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] operation
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [13:8] frame_length, [15:14] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    ctrl_cmd_t        cmd;
    dp_status_t       status;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] frame_length;

    // The controller sequences request intake and result emission.
    frp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the parser, the CRC, the payload store and the
    // output register.
    frp_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .operation      (s_tuser),
        .rx_byte        (s_tdata),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .status         (status),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_kind         (m_tuser),
        .m_data_byte    (data_byte),
        .m_frame_length (frame_length),
        .m_last         (m_tlast)
    );

    assign m_tdata = {2'b00, frame_length, data_byte};

endmodule
